/* sv/amcr_pkg.sv */
// Shared types, constants and helper functions of the box collision resolver.
package amcr_pkg;

  localparam int MAX_BOXES = 64;
  localparam int BOX_AW    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);

  localparam int COORD_W   = 32;
  localparam int SIZE_W    = 24;
  localparam int WIDE_W    = COORD_W + 2;
  localparam int CFG_IDX_W = 2;

  typedef logic        [1:0]           opcode_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic signed [COORD_W-1:0]   coord_t;
  typedef logic        [SIZE_W-1:0]    psize_t;
  typedef logic signed [WIDE_W-1:0]    wide_t;
  typedef logic        [CNT_W-1:0]     count_t;
  typedef logic        [BOX_AW-1:0]    box_addr_t;

  localparam opcode_t OP_ADD   = 2'd0;
  localparam opcode_t OP_CLEAR = 2'd1;
  localparam opcode_t OP_MOVE  = 2'd2;

  localparam cfg_idx_t CFG_SIZE_X = 2'd0;
  localparam cfg_idx_t CFG_SIZE_Y = 2'd1;
  localparam cfg_idx_t CFG_SIZE_Z = 2'd2;

  localparam psize_t RST_SIZE_X = 24'd39322;
  localparam psize_t RST_SIZE_Y = 24'd117965;
  localparam psize_t RST_SIZE_Z = 24'd39322;

  localparam count_t BOX_LIMIT = count_t'(MAX_BOXES);

  typedef struct packed {
    opcode_t opcode;
    coord_t  main_x;
    coord_t  main_y;
    coord_t  main_z;
    coord_t  aux_x;
    coord_t  aux_y;
    coord_t  aux_z;
  } amcr_in_t;

  typedef struct packed {
    coord_t result_x;
    coord_t result_y;
    coord_t result_z;
    logic   blocked;
    logic   status;
  } amcr_out_t;

  typedef struct packed {
    cfg_idx_t idx;
    psize_t   data;
  } amcr_cfg_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t cz;
    coord_t sx;
    coord_t sy;
    coord_t sz;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic write_box;
    logic clear_tab;
    logic scan_rd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    table_full;
    logic    table_empty;
    logic    scan_last;
    logic    pipe_busy;
    logic    out_free;
  } sts_t;

  // Sign extension of a coordinate to the comparison width.
  function automatic wide_t widen(input coord_t v);
    return {{(WIDE_W - COORD_W){v[COORD_W-1]}}, v};
  endfunction

  // Floor half of a signed box size (arithmetic shift).
  function automatic wide_t half_box(input coord_t v);
    wide_t w;
    w = widen(v);
    return w >>> 1;
  endfunction

  // Player sizes are unsigned, so their half is a plain shift.
  function automatic wide_t half_player(input psize_t s);
    return {{(WIDE_W - SIZE_W + 1){1'b0}}, s[SIZE_W-1:1]};
  endfunction

  function automatic wide_t full_player(input psize_t s);
    return {{(WIDE_W - SIZE_W){1'b0}}, s};
  endfunction

  // Strict overlap of two intervals along one axis.
  function automatic logic overlap(input wide_t plo, input wide_t phi,
                                   input wide_t blo, input wide_t bhi);
    return (phi > blo) && (plo < bhi);
  endfunction

endpackage

/* sv/amcr_if.sv */
// Handshake interfaces of the request, result and configuration channels.
interface amcr_in_if;
  import amcr_pkg::*;
  logic     valid;
  logic     ready;
  amcr_in_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

interface amcr_out_if;
  import amcr_pkg::*;
  logic      valid;
  logic      ready;
  amcr_out_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

interface amcr_cfg_if;
  import amcr_pkg::*;
  logic      valid;
  logic      ready;
  amcr_cfg_t wr;
  modport source (output valid, output wr, input ready);
  modport sink (input valid, input wr, output ready);
endinterface

/* sv/aabb_move_collision_resolver_core.sv */
// Top level of the box collision resolver: controller, datapath and channel wiring.
//
//   Channel | Direction | Payload                              | Accepted when
//   --------+-----------+--------------------------------------+------------------------
//   in_ch   | sink      | opcode, main_x/y/z, aux_x/y/z        | valid && ready
//   out_ch  | source    | result_x/y/z, blocked, status        | valid && ready
//   cfg_ch  | sink      | idx (player size register), data     | valid && ready (out of reset)
//
// A move request over N stored boxes, N at least one, passes from acceptance to a loaded
// result through decode, N reads from the single read port of the box memory, the read,
// bounds and compare stages, and the load, which waits until the result side is free.
// A move over an empty table and add, clear and unused-opcode requests go from decode
// straight to the load. The next request is accepted only once the block is back in idle
// after the load, so a new request is not taken before the last one is through.
// After the synchronous, active-low reset the table is empty and the player sizes hold
// their defaults; the box memory itself is not cleared, as only entries below the
// count are ever read. Neither the request nor the configuration side is ready in reset.
// The result register decouples the two sides: a new request is taken while a result
// still waits, and only the final load of the next result waits for the result side.
module aabb_move_collision_resolver_core (
  input  logic        clk,
  input  logic        rst_n,
  amcr_in_if.sink     in_ch,
  amcr_out_if.source  out_ch,
  amcr_cfg_if.sink    cfg_ch
);
  import amcr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // Configuration writes are taken whenever the block is out of reset; the user must let
  // them arrive only while the block is idle, as the block itself does not enforce this.
  assign cfg_ch.ready = rst_n;
  assign cfg_we       = cfg_ch.valid && rst_n;

  // The controller accepts a request only in its idle state and then walks it
  // through execution, the table scan of a move over a filled table, and the result load.
  amcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the box table, the player sizes, the scan pipeline with
  // its four hit flags and the result register.
  amcr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch.req),
    .cfg_we    (cfg_we),
    .cfg_wr    (cfg_ch.wr),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_rsp   (out_ch.rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* sv/amcr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module amcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/amcr_ctrl.sv */
// Controller state machine sequencing add, clear and move requests.
module amcr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  amcr_pkg::sts_t sts,
  output amcr_pkg::cmd_t cmd
);
  import amcr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.op == OP_MOVE && !sts.table_empty) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = rst_n;
        cmd.capture = in_valid && rst_n;
      end
      ST_EXEC: begin
        cmd.write_box = (sts.op == OP_ADD) && !sts.table_full;
        cmd.clear_tab = (sts.op == OP_CLEAR);
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FIN: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/amcr_dp.sv */
// Datapath: box table, configuration, scan pipeline and result register.
module amcr_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  amcr_pkg::amcr_in_t in_req,
  input  logic              cfg_we,
  input  amcr_pkg::amcr_cfg_t cfg_wr,
  input  logic              out_ready,
  output logic              out_valid,
  output amcr_pkg::amcr_out_t out_rsp,
  input  amcr_pkg::cmd_t     cmd,
  output amcr_pkg::sts_t     sts
);
  import amcr_pkg::*;

  // Configuration registers.
  psize_t size_x_r, size_y_r, size_z_r;

  // Captured request.
  opcode_t op_r;
  coord_t  mx_r, my_r, mz_r, ax_r, ay_r, az_r;
  logic    drop_r;

  // Player extents for the new (m) and old (a) value on each axis.
  wide_t xm_lo_r, xm_hi_r, xa_lo_r, xa_hi_r;
  wide_t ym_lo_r, ym_hi_r, ya_lo_r, ya_hi_r;
  wide_t zm_lo_r, zm_hi_r, za_lo_r, za_hi_r;

  // Table and scan state.
  count_t count_r;
  count_t scan_cnt_r;
  logic   rd_v_r;
  logic   bnd_v_r;
  wide_t  bx_lo_r, bx_hi_r, by_lo_r, by_hi_r, bz_lo_r, bz_hi_r;

  // Hit flags: new position, x slide, z slide after x accepted, z slide
  // after x refused.
  logic hit_a_r, hit_b_r, hit_c1_r, hit_c2_r;

  logic      out_valid_r;
  amcr_out_t out_r;

  logic [BOX_W-1:0] ram_rdata;
  box_t             rd_box;
  box_t             wr_box;

  wide_t hx, hy, fy, hz;
  logic  ox_m, ox_a, oy_m, oy_a, oz_m, oz_a;
  logic  slide_z_hit;
  amcr_out_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= RST_SIZE_X;
      size_y_r <= RST_SIZE_Y;
      size_z_r <= RST_SIZE_Z;
    end else if (cfg_we) begin
      case (cfg_wr.idx)
        CFG_SIZE_X: size_x_r <= cfg_wr.data;
        CFG_SIZE_Y: size_y_r <= cfg_wr.data;
        CFG_SIZE_Z: size_z_r <= cfg_wr.data;
        default: begin
        end
      endcase
    end
  end

  assign hx = half_player(size_x_r);
  assign hy = half_player(size_y_r);
  assign fy = full_player(size_y_r);
  assign hz = half_player(size_z_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_req.opcode;
      mx_r    <= in_req.main_x;
      my_r    <= in_req.main_y;
      mz_r    <= in_req.main_z;
      ax_r    <= in_req.aux_x;
      ay_r    <= in_req.aux_y;
      az_r    <= in_req.aux_z;
      drop_r  <= (count_r == BOX_LIMIT);
      xm_lo_r <= widen(in_req.main_x) - hx;
      xm_hi_r <= widen(in_req.main_x) + hx;
      xa_lo_r <= widen(in_req.aux_x) - hx;
      xa_hi_r <= widen(in_req.aux_x) + hx;
      ym_lo_r <= widen(in_req.main_y) - hy;
      ym_hi_r <= widen(in_req.main_y) + fy;
      ya_lo_r <= widen(in_req.aux_y) - hy;
      ya_hi_r <= widen(in_req.aux_y) + fy;
      zm_lo_r <= widen(in_req.main_z) - hz;
      zm_hi_r <= widen(in_req.main_z) + hz;
      za_lo_r <= widen(in_req.aux_z) - hz;
      za_hi_r <= widen(in_req.aux_z) + hz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear_tab) begin
      count_r <= '0;
    end else if (cmd.write_box) begin
      count_r <= count_r + 1'b1;
    end
  end

  assign wr_box = '{cx: mx_r, cy: my_r, cz: mz_r, sx: ax_r, sy: ay_r, sz: az_r};

  amcr_ram #(
    .WIDTH (BOX_W),
    .DEPTH (MAX_BOXES)
  ) u_box_ram (
    .clk   (clk),
    .we    (cmd.write_box),
    .waddr (count_r[BOX_AW-1:0]),
    .wdata (wr_box),
    .re    (cmd.scan_rd),
    .raddr (scan_cnt_r[BOX_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_box = box_t'(ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      rd_v_r     <= 1'b0;
      bnd_v_r    <= 1'b0;
    end else begin
      rd_v_r  <= cmd.scan_rd;
      bnd_v_r <= rd_v_r;
      if (cmd.capture) begin
        scan_cnt_r <= '0;
      end else if (cmd.scan_rd) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
    end
  end

  // Box bounds stage.
  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      bx_lo_r <= widen(rd_box.cx) - half_box(rd_box.sx);
      bx_hi_r <= widen(rd_box.cx) + half_box(rd_box.sx);
      by_lo_r <= widen(rd_box.cy) - half_box(rd_box.sy);
      by_hi_r <= widen(rd_box.cy) + half_box(rd_box.sy);
      bz_lo_r <= widen(rd_box.cz) - half_box(rd_box.sz);
      bz_hi_r <= widen(rd_box.cz) + half_box(rd_box.sz);
    end
  end

  // Compare stage: per-axis overlaps, combined into the four candidates.
  assign ox_m = overlap(xm_lo_r, xm_hi_r, bx_lo_r, bx_hi_r);
  assign ox_a = overlap(xa_lo_r, xa_hi_r, bx_lo_r, bx_hi_r);
  assign oy_m = overlap(ym_lo_r, ym_hi_r, by_lo_r, by_hi_r);
  assign oy_a = overlap(ya_lo_r, ya_hi_r, by_lo_r, by_hi_r);
  assign oz_m = overlap(zm_lo_r, zm_hi_r, bz_lo_r, bz_hi_r);
  assign oz_a = overlap(za_lo_r, za_hi_r, bz_lo_r, bz_hi_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit_a_r  <= 1'b0;
      hit_b_r  <= 1'b0;
      hit_c1_r <= 1'b0;
      hit_c2_r <= 1'b0;
    end else if (bnd_v_r) begin
      hit_a_r  <= hit_a_r  | (ox_m & oy_m & oz_m);
      hit_b_r  <= hit_b_r  | (ox_m & oy_a & oz_a);
      hit_c1_r <= hit_c1_r | (ox_m & oy_a & oz_m);
      hit_c2_r <= hit_c2_r | (ox_a & oy_a & oz_m);
    end
  end

  // Result selection. When the x slide is refused the z slide is tested
  // with the old x, otherwise with the new one.
  assign slide_z_hit = hit_b_r ? hit_c2_r : hit_c1_r;

  always_comb begin
    res = '0;
    if (op_r == OP_MOVE) begin
      if (!hit_a_r) begin
        res.result_x = mx_r;
        res.result_y = my_r;
        res.result_z = mz_r;
      end else begin
        res.blocked  = 1'b1;
        res.result_x = hit_b_r ? ax_r : mx_r;
        res.result_y = ay_r;
        res.result_z = slide_z_hit ? az_r : mz_r;
      end
    end else if (op_r == OP_ADD) begin
      res.status = drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  assign sts.op          = op_r;
  assign sts.table_full  = (count_r == BOX_LIMIT);
  assign sts.table_empty = (count_r == '0);
  assign sts.scan_last   = (count_t'(scan_cnt_r + 1'b1) == count_r);
  assign sts.pipe_busy   = rd_v_r | bnd_v_r;
  assign sts.out_free    = !out_valid_r || out_ready;

endmodule
